// ===== design/aabb_bvh_overlap_query_macros.svh =====
// Assertion macros for the overlap query block
`ifndef AABB_BVH_OVERLAP_QUERY_MACROS_SVH
`define AABB_BVH_OVERLAP_QUERY_MACROS_SVH
`ifndef SYNTHESIS
`define ABQ_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define ABQ_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`else
`define ABQ_ASSERT_IMP(label, clk, rst_n, a, c, msg)
`define ABQ_ASSERT_NXT(label, clk, rst_n, a, c, msg)
`endif
`endif

// ===== design/abq_pkg.sv =====
// ----------------------------------------------------------------------------
// abq_pkg
// Shared constants and types for the box tree overlap query block.
// ----------------------------------------------------------------------------
package abq_pkg;
    localparam int MAX_LEAVES_DEF = 32;
    localparam int COORD_BITS_DEF = 24;
    localparam int RES_CAP        = 32;
    localparam int ID_BITS        = 5;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_COPY  = 8'b0000_0010,
        S_WRITE = 8'b0000_0100,
        S_RFRD  = 8'b0000_1000,
        S_RFWR  = 8'b0001_0000,
        S_QRD   = 8'b0010_0000,
        S_QCHK  = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;
endpackage

// ===== design/aabb_bvh_overlap_query.sv =====
// ----------------------------------------------------------------------------
// aabb_bvh_overlap_query
// Box tree in heap order with leaf insert and depth-first overlap query.
// ----------------------------------------------------------------------------
// Each word is handled alone; s_axis_tready is high only when idle, so one
// item is finished before the next is taken. An insert into a tree of k
// leaves (k > 0) runs a copy read, copy write and new leaf write, then a
// sibling read and a refit write per ancestor through the node memory, and
// loads the result register last. The first leaf is written directly; a
// rejected insert or a query on an empty tree goes straight to the result
// word. A query does a memory read, then an overlap compare, for each
// visited node, and loads the final word last; a hit waits while the output
// register is full. Hits are held one word behind the walk so that the
// final one carries tlast. Results leave through a one-word output register.
// Node memories are not cleared; unwritten slots are never visited.
`include "aabb_bvh_overlap_query_macros.svh"
module aabb_bvh_overlap_query #(
    parameter int MAX_LEAVES = abq_pkg::MAX_LEAVES_DEF,
    parameter int COORD_BITS = abq_pkg::COORD_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // tdata: min_x, min_y, min_z, max_x, max_y, max_z from the lowest bit up
    input  logic [((6*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    // tuser: mode
    input  logic                    s_axis_tuser,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // tdata: hit, leaf_id, full_res from the lowest bit up
    output logic [7:0]              m_axis_tdata,
    output logic                    m_axis_tlast
);
    localparam int SLOTS  = 2 * MAX_LEAVES;
    localparam int SB     = $clog2(SLOTS);
    localparam int CB     = $clog2(MAX_LEAVES + 1);
    localparam int BB     = 6 * COORD_BITS;
    localparam int DEPTHB = $clog2(SB + 1);
    localparam int RB     = $clog2(abq_pkg::RES_CAP + 1);
    localparam int IDB    = abq_pkg::ID_BITS;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    abq_pkg::t_state r_state, n_state;

    // node memory: box and leaf number per slot
    logic [BB-1:0]  mem_box [SLOTS];
    logic [IDB-1:0] mem_id  [SLOTS];
    logic [SB-1:0]  rd_addr;
    logic [BB-1:0]  r_rd_box;
    logic [IDB-1:0] r_rd_id;
    logic           wr_en;
    logic [SB-1:0]  wr_addr;
    logic [BB-1:0]  wr_box;
    logic [IDB-1:0] wr_id;

    logic [CB-1:0]  r_count, n_count;
    logic [BB-1:0]  r_qbox, n_qbox;
    logic [BB-1:0]  r_acc, n_acc;
    logic [SB:0]    r_node, n_node;
    logic [SB:0]    r_stack [SB+1];
    logic [DEPTHB-1:0] r_sp, n_sp;
    logic           push;
    logic [SB:0]    push_val;
    logic [RB-1:0]  r_nres, n_nres;
    logic           r_ovalid, n_ovalid;
    logic [7:0]     r_odata, n_odata;
    logic           r_olast, n_olast;
    logic           r_pend, n_pend;
    logic [7:0]     r_pdata, n_pdata;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_box[wr_addr] <= wr_box;
            mem_id[wr_addr]  <= wr_id;
        end
        r_rd_box <= mem_box[rd_addr];
        r_rd_id  <= mem_id[rd_addr];
    end

    function automatic t_coord fld(logic [BB-1:0] b, int i);
        return b[i*COORD_BITS +: COORD_BITS];
    endfunction

    // shared compare unit: merge or overlap test
    logic [BB-1:0] merged;
    logic          ovl;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            merged[i*COORD_BITS +: COORD_BITS] =
                (fld(r_rd_box, i) < fld(r_acc, i)) ? fld(r_rd_box, i) : fld(r_acc, i);
            merged[(i+3)*COORD_BITS +: COORD_BITS] =
                (fld(r_rd_box, i+3) > fld(r_acc, i+3)) ? fld(r_rd_box, i+3)
                                                        : fld(r_acc, i+3);
        end
        ovl = 1'b1;
        for (int i = 0; i < 3; i++) begin
            if (!(fld(r_rd_box, i) <= fld(r_qbox, i+3) &&
                  fld(r_qbox, i) <= fld(r_rd_box, i+3)))
                ovl = 1'b0;
        end
    end

    logic out_free;
    logic [SB:0] cnt_ext, two_cnt;
    assign cnt_ext  = (SB+1)'(r_count);
    assign two_cnt  = cnt_ext << 1;
    assign out_free = !r_ovalid || m_axis_tready;

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_qbox   = r_qbox;
        n_acc    = r_acc;
        n_node   = r_node;
        n_sp     = r_sp;
        n_nres   = r_nres;
        n_ovalid = r_ovalid && !m_axis_tready;
        n_odata  = r_odata;
        n_olast  = r_olast;
        n_pend   = r_pend;
        n_pdata  = r_pdata;
        rd_addr  = r_node[SB-1:0];
        wr_en    = 1'b0;
        wr_addr  = r_node[SB-1:0];
        wr_box   = r_acc;
        wr_id    = r_rd_id;
        push     = 1'b0;
        push_val = '0;
        unique case (r_state)
            abq_pkg::S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_qbox = s_axis_tdata[BB-1:0];
                    n_acc  = s_axis_tdata[BB-1:0];
                    n_nres = '0;
                    if (s_axis_tuser) begin
                        n_node  = (SB+1)'(1);
                        n_sp    = '0;
                        n_state = (r_count == '0) ? abq_pkg::S_OUT : abq_pkg::S_QRD;
                        n_pend  = 1'b0;
                    end else if (r_count >= CB'(MAX_LEAVES)) begin
                        n_pdata = 8'(1 << (IDB + 1));
                        n_pend  = 1'b1;
                        n_state = abq_pkg::S_OUT;
                    end else if (r_count == '0) begin
                        n_node  = (SB+1)'(1);
                        n_state = abq_pkg::S_WRITE;
                    end else begin
                        n_node  = cnt_ext;
                        n_state = abq_pkg::S_COPY;
                    end
                end
            end
            // old leaf moves to 2k+1; its data was read with address k
            abq_pkg::S_COPY: begin
                n_state = abq_pkg::S_WRITE;
                n_node  = two_cnt;
            end
            abq_pkg::S_WRITE: begin
                wr_en   = 1'b1;
                wr_box  = r_qbox;
                wr_id   = IDB'(r_count);
                if (r_node == two_cnt) begin
                    // copy of old leaf first, then the new leaf next cycle
                    wr_addr = SB'(two_cnt + 1'b1);
                    wr_box  = r_rd_box;
                    wr_id   = r_rd_id;
                    n_state = abq_pkg::S_RFWR;
                    n_node  = cnt_ext;
                end else begin
                    n_pdata = 8'({IDB'(r_count), 1'b0});
                    n_count = r_count + 1'b1;
                    n_pend  = 1'b1;
                    n_state = abq_pkg::S_OUT;
                end
            end
            // write new leaf, then refit ancestors: acc holds the child box
            abq_pkg::S_RFWR: begin
                wr_en   = 1'b1;
                if (r_node == cnt_ext && r_nres == '0) begin
                    wr_addr = SB'(two_cnt);
                    wr_box  = r_qbox;
                    wr_id   = IDB'(r_count);
                    n_nres  = RB'(1);
                    n_node  = two_cnt;
                    n_state = abq_pkg::S_RFRD;
                end else begin
                    wr_box  = merged;
                    n_acc   = merged;
                    if (r_node == (SB+1)'(1)) begin
                        n_pdata = 8'({IDB'(r_count), 1'b0});
                        n_count = r_count + 1'b1;
                        n_pend  = 1'b1;
                        n_nres  = '0;
                        n_state = abq_pkg::S_OUT;
                    end else begin
                        n_state = abq_pkg::S_RFRD;
                    end
                end
            end
            // read the sibling of the child, advance to its parent
            abq_pkg::S_RFRD: begin
                rd_addr = SB'(r_node ^ (SB+1)'(1));
                n_node  = r_node >> 1;
                n_state = abq_pkg::S_RFWR;
            end
            abq_pkg::S_QRD: begin
                n_state = abq_pkg::S_QCHK;
            end
            abq_pkg::S_QCHK: begin
                if (ovl && r_node >= cnt_ext) begin
                    // hold the new hit, send the one held before it
                    if (!r_pend || out_free) begin
                        if (r_pend) begin
                            n_ovalid = 1'b1;
                            n_odata  = r_pdata;
                            n_olast  = 1'b0;
                        end
                        n_pdata = 8'({r_rd_id, 1'b1});
                        n_pend  = 1'b1;
                        n_nres  = r_nres + 1'b1;
                        if (r_sp == '0 || r_nres == RB'(abq_pkg::RES_CAP - 1)) begin
                            n_state = abq_pkg::S_OUT;
                        end else begin
                            n_sp    = r_sp - 1'b1;
                            n_node  = r_stack[r_sp - 1'b1];
                            n_state = abq_pkg::S_QRD;
                        end
                    end
                end else if (ovl) begin
                    push     = 1'b1;
                    push_val = (r_node << 1) | (SB+1)'(1);
                    n_sp     = r_sp + 1'b1;
                    n_node   = r_node << 1;
                    n_state  = abq_pkg::S_QRD;
                end else if (r_sp != '0) begin
                    n_sp    = r_sp - 1'b1;
                    n_node  = r_stack[r_sp - 1'b1];
                    n_state = abq_pkg::S_QRD;
                end else begin
                    n_state = abq_pkg::S_OUT;
                end
            end
            // final word: insert, full, last hit or empty query
            abq_pkg::S_OUT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_odata  = r_pend ? r_pdata : 8'h00;
                    n_olast  = 1'b1;
                    n_pend   = 1'b0;
                    n_state  = abq_pkg::S_IDLE;
                end
            end
            default: n_state = abq_pkg::S_IDLE;
        endcase
        // read address on accept: leaf slot k for an insert, slot 1 for a query; in check the next node
        if (r_state == abq_pkg::S_IDLE && s_axis_tvalid && !s_axis_tuser)
            rd_addr = SB'(cnt_ext);
        if (r_state == abq_pkg::S_QCHK)
            rd_addr = n_node[SB-1:0];
        if (r_state == abq_pkg::S_IDLE && s_axis_tvalid && s_axis_tuser)
            rd_addr = SB'(1);
    end

    assign s_axis_tready = (r_state == abq_pkg::S_IDLE);

    // hold the right-child stack
    always_ff @(posedge i_clk) begin
        if (push) r_stack[r_sp[DEPTHB-1:0]] <= push_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= abq_pkg::S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
            r_pend   <= 1'b0;
            r_sp     <= '0;
            r_nres   <= '0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
            r_pend   <= n_pend;
            r_sp     <= n_sp;
            r_nres   <= n_nres;
        end
        r_qbox  <= n_qbox;
        r_acc   <= n_acc;
        r_node  <= n_node;
        r_odata <= n_odata;
        r_olast <= n_olast;
        r_pdata <= n_pdata;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;

    `ABQ_ASSERT_IMP(a_cnt_max, i_clk, i_rst_n, 1'b1, r_count <= CB'(MAX_LEAVES), "count")
    `ABQ_ASSERT_NXT(a_hold, i_clk, i_rst_n, r_ovalid && !m_axis_tready, r_ovalid && $stable(r_odata), "drop")
    `ABQ_ASSERT_IMP(a_busy, i_clk, i_rst_n, r_state != abq_pkg::S_IDLE, !s_axis_tready, "busy")
endmodule
